[sv/nbtp_pkg.sv]
// Shared types, codes and constants of the nested block token parser.
package nbtp_pkg;

    // Field widths and limits
    localparam int ID_BITS    = 16;
    localparam int DEPTH_BITS = 8;
    localparam int ARGS_BITS  = 4;
    localparam int MAX_DEPTH  = 255;
    localparam int MAX_ARGS   = 15;

    // Result queue geometry
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    // Token kinds
    localparam logic [2:0] K_EOI     = 3'd0;
    localparam logic [2:0] K_BARE    = 3'd1;
    localparam logic [2:0] K_QUOTED  = 3'd2;
    localparam logic [2:0] K_COMMENT = 3'd3;
    localparam logic [2:0] K_CODE    = 3'd4;
    localparam logic [2:0] K_LIT     = 3'd5;
    localparam logic [2:0] K_OTHER   = 3'd6;
    localparam logic [2:0] K_RESTART = 3'd7;

    // Result actions
    localparam logic [2:0] A_COMMAND   = 3'd0;
    localparam logic [2:0] A_COMMENT   = 3'd1;
    localparam logic [2:0] A_CODE      = 3'd2;
    localparam logic [2:0] A_BLOCK     = 3'd3;
    localparam logic [2:0] A_BLOCK_END = 3'd4;
    localparam logic [2:0] A_END       = 3'd5;
    localparam logic [2:0] A_ARG       = 3'd6;
    localparam logic [2:0] A_ERROR     = 3'd7;

    // Error codes
    localparam logic [2:0] E_END_OPEN   = 3'd0;
    localparam logic [2:0] E_CLOSE_NONE = 3'd1;
    localparam logic [2:0] E_BAD_LIT    = 3'd2;
    localparam logic [2:0] E_BAD_KIND   = 3'd3;
    localparam logic [2:0] E_TOO_DEEP   = 3'd4;
    localparam logic [2:0] E_TOO_MANY   = 3'd5;

    // Literal characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Grammar state, one-hot
    typedef enum logic [5:0] {
        ST_TOP     = 6'b000001,
        ST_NAME    = 6'b000010,
        ST_ARG     = 6'b000100,
        ST_ARGCONT = 6'b001000,
        ST_TAIL    = 6'b010000,
        ST_HALT    = 6'b100000
    } gstate_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         lit_char;
        logic [ID_BITS-1:0] token_id;
    } tok_beat_t;

    typedef struct packed {
        logic [2:0]            action;
        logic [ID_BITS-1:0]    name_id;
        logic [ID_BITS-1:0]    token_ref;
        logic [ARGS_BITS-1:0]  arg_count;
        logic                  has_body;
        logic [2:0]            error_code;
        logic [DEPTH_BITS-1:0] nesting;
        logic                  last;
    } res_beat_t;

    typedef struct packed {
        gstate_t               gstate;
        logic [DEPTH_BITS-1:0] depth;
        logic [ID_BITS-1:0]    held;
        logic [ARGS_BITS-1:0]  args;
    } parse_state_t;

    // Decoder to queue: what one token pushes
    typedef struct packed {
        logic [1:0] count;
        res_beat_t  res0;
        res_beat_t  res1;
    } push_t;

endpackage

[sv/nbtp_decode.sv]
// Combinational grammar step: next parser state and up to two results per token.
module nbtp_decode (
    input  nbtp_pkg::parse_state_t cur,
    input  nbtp_pkg::tok_beat_t    beat,
    output nbtp_pkg::parse_state_t nxt,
    output nbtp_pkg::push_t        push
);
    import nbtp_pkg::*;

    typedef struct packed {
        logic         hit;
        res_beat_t    res;
        parse_state_t st;
    } top_step_t;

    function automatic res_beat_t mk_res(input logic [2:0] action,
                                         input logic [ID_BITS-1:0] name,
                                         input logic [ID_BITS-1:0] ref_id,
                                         input logic [ARGS_BITS-1:0] cnt,
                                         input logic body,
                                         input logic [2:0] err,
                                         input logic [DEPTH_BITS-1:0] nest);
        res_beat_t r;
        r.action     = action;
        r.name_id    = name;
        r.token_ref  = ref_id;
        r.arg_count  = cnt;
        r.has_body   = body;
        r.error_code = err;
        r.nesting    = nest;
        r.last       = 1'b0;
        return r;
    endfunction

    // Handling of one token in the top-level state
    function automatic top_step_t top_level(input parse_state_t s, input tok_beat_t b);
        top_step_t t;
        t.hit = 1'b1;
        t.st  = s;
        t.st.gstate = ST_TOP;
        t.res = '0;
        case (b.kind)
            K_EOI:
            begin
                if (s.depth != '0)
                begin
                    t.st.gstate = ST_HALT;
                    t.res = mk_res(A_ERROR, '0, b.token_id, '0, 1'b0, E_END_OPEN, s.depth);
                end
                else
                begin
                    t.res = mk_res(A_END, '0, '0, '0, 1'b0, '0, s.depth);
                end
            end
            K_BARE:
            begin
                t.hit = 1'b0;
                t.st.held = b.token_id;
                t.st.gstate = ST_NAME;
            end
            K_COMMENT:
            begin
                t.res = mk_res(A_COMMENT, '0, b.token_id, '0, 1'b0, '0, s.depth);
            end
            K_CODE:
            begin
                t.res = mk_res(A_CODE, '0, b.token_id, '0, 1'b0, '0, s.depth);
            end
            K_LIT:
            begin
                if (b.lit_char != CH_RBRACE)
                begin
                    t.st.gstate = ST_HALT;
                    t.res = mk_res(A_ERROR, '0, b.token_id, '0, 1'b0, E_BAD_LIT, s.depth);
                end
                else if (s.depth == '0)
                begin
                    t.st.gstate = ST_HALT;
                    t.res = mk_res(A_ERROR, '0, b.token_id, '0, 1'b0, E_CLOSE_NONE, s.depth);
                end
                else
                begin
                    t.st.depth = s.depth - 1'b1;
                    t.res = mk_res(A_BLOCK_END, '0, '0, '0, 1'b0, '0, t.st.depth);
                end
            end
            default:
            begin
                t.st.gstate = ST_HALT;
                t.res = mk_res(A_ERROR, '0, b.token_id, '0, 1'b0, E_BAD_KIND, s.depth);
            end
        endcase
        return t;
    endfunction

    top_step_t             top_t;
    top_step_t             tail_t;
    parse_state_t          tail_s;
    logic                  is_word;
    logic                  is_lit;
    logic [ID_BITS-1:0]    tok;
    logic [DEPTH_BITS-1:0] dep;
    res_beat_t             r0;
    res_beat_t             r1;
    logic [1:0]            n;

    assign is_word = (beat.kind == K_BARE) || (beat.kind == K_QUOTED);
    assign is_lit  = (beat.kind == K_LIT);
    assign tok     = beat.token_id;
    assign dep     = cur.depth;

    // Header without body: state after emitting the block, fed to top level
    always_comb
    begin
        tail_s        = cur;
        tail_s.gstate = ST_TOP;
        tail_s.held   = '0;
        tail_s.args   = '0;
    end

    assign top_t  = top_level(cur, beat);
    assign tail_t = top_level(tail_s, beat);

    // Grammar step
    always_comb
    begin
        nxt = cur;
        r0  = '0;
        r1  = '0;
        n   = 2'd0;
        if (beat.kind == K_RESTART)
        begin
            nxt.gstate = ST_TOP;
            nxt.depth  = '0;
            nxt.held   = '0;
            nxt.args   = '0;
        end
        else
        begin
            case (cur.gstate)
                ST_TOP:
                begin
                    nxt = top_t.st;
                    r0  = top_t.res;
                    n   = {1'b0, top_t.hit};
                end
                ST_NAME:
                begin
                    n = 2'd1;
                    if (is_word)
                    begin
                        r0 = mk_res(A_COMMAND, cur.held, tok, '0, 1'b0, '0, dep);
                        nxt.held   = '0;
                        nxt.gstate = ST_TOP;
                    end
                    else if (is_lit && beat.lit_char == CH_LPAREN)
                    begin
                        n = 2'd0;
                        nxt.args   = '0;
                        nxt.gstate = ST_ARG;
                    end
                    else
                    begin
                        nxt.gstate = ST_HALT;
                        r0 = mk_res(A_ERROR, '0, tok, '0, 1'b0,
                                    is_lit ? E_BAD_LIT : E_BAD_KIND, dep);
                    end
                end
                ST_ARG:
                begin
                    n = 2'd1;
                    if (is_word)
                    begin
                        if (cur.args >= ARGS_BITS'(MAX_ARGS))
                        begin
                            nxt.gstate = ST_HALT;
                            r0 = mk_res(A_ERROR, '0, tok, '0, 1'b0, E_TOO_MANY, dep);
                        end
                        else
                        begin
                            nxt.args   = cur.args + 1'b1;
                            nxt.gstate = ST_ARGCONT;
                            r0 = mk_res(A_ARG, cur.held, tok, '0, 1'b0, '0, dep);
                        end
                    end
                    else if (is_lit && beat.lit_char == CH_RPAREN)
                    begin
                        n = 2'd0;
                        nxt.gstate = ST_TAIL;
                    end
                    else
                    begin
                        nxt.gstate = ST_HALT;
                        r0 = mk_res(A_ERROR, '0, tok, '0, 1'b0,
                                    is_lit ? E_BAD_LIT : E_BAD_KIND, dep);
                    end
                end
                ST_ARGCONT:
                begin
                    if (is_lit && beat.lit_char == CH_COMMA)
                    begin
                        nxt.gstate = ST_ARG;
                    end
                    else if (is_lit && beat.lit_char == CH_RPAREN)
                    begin
                        nxt.gstate = ST_TAIL;
                    end
                    else
                    begin
                        n = 2'd1;
                        nxt.gstate = ST_HALT;
                        r0 = mk_res(A_ERROR, '0, tok, '0, 1'b0,
                                    is_lit ? E_BAD_LIT : E_BAD_KIND, dep);
                    end
                end
                ST_TAIL:
                begin
                    n = 2'd1;
                    if (is_lit && beat.lit_char == CH_LBRACE)
                    begin
                        if (dep >= DEPTH_BITS'(MAX_DEPTH))
                        begin
                            nxt.gstate = ST_HALT;
                            r0 = mk_res(A_ERROR, '0, tok, '0, 1'b0, E_TOO_DEEP, dep);
                        end
                        else
                        begin
                            nxt.depth  = dep + 1'b1;
                            nxt.gstate = ST_TOP;
                            nxt.held   = '0;
                            nxt.args   = '0;
                            r0 = mk_res(A_BLOCK, cur.held, '0, cur.args, 1'b1, '0,
                                        dep + 1'b1);
                        end
                    end
                    else
                    begin
                        // Block without body, then the token is handled at top level
                        r0  = mk_res(A_BLOCK, cur.held, '0, cur.args, 1'b0, '0, dep);
                        r1  = tail_t.res;
                        nxt = tail_t.st;
                        n   = tail_t.hit ? 2'd2 : 2'd1;
                    end
                end
                default:
                begin
                    // Halted: ignore everything but restart
                    n = 2'd0;
                end
            endcase
        end
        // Mark the final result of this token
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign push.count = n;
    assign push.res0  = r0;
    assign push.res1  = r1;

endmodule

[sv/nbtp_res_queue.sv]
// Small result queue: takes up to two result beats a cycle, delivers one unless stalled.
module nbtp_res_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  nbtp_pkg::push_t     push,
    output logic                room,
    output logic                res_valid,
    input  logic                res_stall,
    output nbtp_pkg::res_beat_t res
);
    import nbtp_pkg::*;

    res_beat_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg;
    logic [Q_CNT_BITS-1:0] count_next;
    logic                  pop;
    logic [Q_PTR_BITS-1:0] wr_ptr_p1;

    assign res_valid = (count_reg != '0);
    assign res       = entry_reg[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;
    // Room for a worst-case token of two results
    assign room      = (count_reg <= Q_CNT_BITS'(Q_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + Q_PTR_BITS'(pop);
        count_next  = count_reg + Q_CNT_BITS'(push.count) - Q_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_p1] <= push.res1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_BITS'(Q_DEPTH))
        else $error("result queue overfilled");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

endmodule

[sv/nested_block_token_parser.sv]
// Top level of the nested block token parser: token register, parser state, result queue.
//
// Usage:
//   Token channel (tok_valid, tok_stall, tok): one lexer token per beat. A beat is
//   taken at a rising edge with tok_valid high and tok_stall low.
//   Result channel (res_valid, res_stall, res): parser actions, one per beat; the
//   final action caused by a token carries last = 1. Tokens that only move the
//   grammar (a name, '(' ')' ',', restart, anything while halted) give no beat.
//   A token is registered in the token register, parsed from there and written
//   into the result queue, whose head entry is offered as the result beat.
//   Throughput: one token per cycle while tokens give at most one result each and
//   the receiver does not stall; a token that closes a bodiless block header gives
//   two results, which the output side delivers one per beat. The four-entry
//   result queue sets this.
//   Reset clears the grammar to top level, depth, held name and argument count to
//   zero and empties both the token register and the result queue.
//   When the receiver stalls, results wait in the queue; once it cannot hold two
//   more, the token register holds and tok_stall rises until space frees up.
//   After an error the parser ignores tokens until a restart token.
module nested_block_token_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    output logic                tok_stall,
    input  nbtp_pkg::tok_beat_t tok,
    output logic                res_valid,
    input  logic                res_stall,
    output nbtp_pkg::res_beat_t res
);
    import nbtp_pkg::*;

    tok_beat_t    tok_reg;
    logic         tok_full_reg;
    logic         tok_full_next;
    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t dec_next;
    push_t        dec_push;
    push_t        push;
    logic         room;
    logic         advance;
    logic         take;

    // Token register handshake
    assign advance   = tok_full_reg && room;
    assign tok_stall = tok_full_reg && !room;
    assign take      = tok_valid && !tok_stall;

    always_comb
    begin
        tok_full_next = tok_full_reg;
        if (take)
        begin
            tok_full_next = 1'b1;
        end
        else if (advance)
        begin
            tok_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_full_reg <= 1'b0;
        end
        else
        begin
            tok_full_reg <= tok_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= tok;
        end
    end

    // Grammar step
    nbtp_decode u_decode (
        .cur  (st_reg),
        .beat (tok_reg),
        .nxt  (dec_next),
        .push (dec_push)
    );

    always_comb
    begin
        st_next = advance ? dec_next : st_reg;
        push    = dec_push;
        if (!advance)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.gstate <= ST_TOP;
            st_reg.depth  <= '0;
            st_reg.held   <= '0;
            st_reg.args   <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Result queue
    nbtp_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tok_reg.kind == K_RESTART)
            |=> (st_reg.gstate == ST_TOP && st_reg.depth == '0))
        else $error("restart did not return parser to top level");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.gstate == ST_HALT) |-> (push.count == 2'd0))
        else $error("halted parser produced a result");

endmodule

[tb/tb.sv]
// Self-checking testbench for the nested block token parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nbtp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES  = 300;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      tok_valid = 1'b0;
    logic      tok_stall;
    tok_beat_t tok = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_beat_t res;

    // Predicted parser state
    gstate_t       ps_state = ST_TOP;
    logic [7:0]    ps_depth = '0;
    logic [15:0]   ps_held = '0;
    logic [3:0]    ps_args = '0;
    res_beat_t     step_res[$];
    res_beat_t     pending_actions[$];

    int  failures = 0;
    int  beats_checked = 0;
    int  tokens_live = 0;
    int  tokens_ignored = 0;
    int  cycle_count = 0;
    int  hold_len = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;

    nested_block_token_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_actions.size());
            $display("nested_block_token_parser verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------
    function automatic void clear_parser();
        ps_state = ST_TOP;
        ps_depth = '0;
        ps_held  = '0;
        ps_args  = '0;
    endfunction

    function automatic void push_action(input logic [2:0] action, input logic [15:0] name,
                                        input logic [15:0] tref, input logic [3:0] cnt,
                                        input logic body, input logic [2:0] err);
        res_beat_t r;
        r.action     = action;
        r.name_id    = name;
        r.token_ref  = tref;
        r.arg_count  = cnt;
        r.has_body   = body;
        r.error_code = err;
        r.nesting    = ps_depth;
        r.last       = 1'b0;
        step_res.insert(step_res.size(), r);
    endfunction

    // An error is reported once, then the parser halts
    function automatic void raise_error(input logic [2:0] err, input logic [15:0] id);
        ps_state = ST_HALT;
        push_action(A_ERROR, '0, id, '0, 1'b0, err);
    endfunction

    function automatic void parse_top(input logic [2:0] kind, input logic [7:0] ch,
                                      input logic [15:0] id);
        case (kind)
            K_EOI:
                if (ps_depth != 0)
                    raise_error(E_END_OPEN, id);
                else
                    push_action(A_END, '0, '0, '0, 1'b0, '0);
            K_BARE:
            begin
                ps_held  = id;
                ps_state = ST_NAME;
            end
            K_COMMENT:
                push_action(A_COMMENT, '0, id, '0, 1'b0, '0);
            K_CODE:
                push_action(A_CODE, '0, id, '0, 1'b0, '0);
            K_LIT:
                if (ch != CH_RBRACE)
                    raise_error(E_BAD_LIT, id);
                else if (ps_depth == 0)
                    raise_error(E_CLOSE_NONE, id);
                else
                begin
                    ps_depth--;
                    push_action(A_BLOCK_END, '0, '0, '0, 1'b0, '0);
                end
            default:
                raise_error(E_BAD_KIND, id);
        endcase
    endfunction

    // Works out the results of one accepted token and queues them
    function automatic void parse_token(input logic [2:0] kind, input logic [7:0] ch,
                                        input logic [15:0] id);
        step_res.delete();
        if (kind == K_RESTART)
        begin
            clear_parser();
            return;
        end
        case (ps_state)
            ST_TOP:
                parse_top(kind, ch, id);
            ST_NAME:
                if (kind == K_BARE || kind == K_QUOTED)
                begin
                    push_action(A_COMMAND, ps_held, id, '0, 1'b0, '0);
                    ps_held  = '0;
                    ps_state = ST_TOP;
                end
                else if (kind == K_LIT)
                begin
                    if (ch == CH_LPAREN)
                    begin
                        ps_args  = '0;
                        ps_state = ST_ARG;
                    end
                    else
                        raise_error(E_BAD_LIT, id);
                end
                else
                    raise_error(E_BAD_KIND, id);
            ST_ARG:
                if (kind == K_BARE || kind == K_QUOTED)
                begin
                    if (ps_args >= MAX_ARGS)
                        raise_error(E_TOO_MANY, id);
                    else
                    begin
                        ps_args++;
                        push_action(A_ARG, ps_held, id, '0, 1'b0, '0);
                        ps_state = ST_ARGCONT;
                    end
                end
                else if (kind == K_LIT)
                begin
                    if (ch == CH_RPAREN)
                        ps_state = ST_TAIL;
                    else
                        raise_error(E_BAD_LIT, id);
                end
                else
                    raise_error(E_BAD_KIND, id);
            ST_ARGCONT:
                if (kind != K_LIT)
                    raise_error(E_BAD_KIND, id);
                else if (ch == CH_COMMA)
                    ps_state = ST_ARG;
                else if (ch == CH_RPAREN)
                    ps_state = ST_TAIL;
                else
                    raise_error(E_BAD_LIT, id);
            ST_TAIL:
                if (kind == K_LIT && ch == CH_LBRACE)
                begin
                    if (ps_depth >= MAX_DEPTH)
                        raise_error(E_TOO_DEEP, id);
                    else
                    begin
                        ps_depth++;
                        push_action(A_BLOCK, ps_held, '0, ps_args, 1'b1, '0);
                        ps_state = ST_TOP;
                        ps_held  = '0;
                        ps_args  = '0;
                    end
                end
                else
                begin
                    // Header without body: close it, then the token counts at top level
                    push_action(A_BLOCK, ps_held, '0, ps_args, 1'b0, '0);
                    ps_state = ST_TOP;
                    ps_held  = '0;
                    ps_args  = '0;
                    parse_top(kind, ch, id);
                end
            default:
                ;
        endcase
        if (step_res.size() != 0)
        begin
            step_res[step_res.size() - 1].last = 1'b1;
            foreach (step_res[i])
                pending_actions.insert(pending_actions.size(), step_res[i]);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_beat_t want;
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
        begin
            beats_checked++;
            if (pending_actions.size() == 0)
            begin
                $error("result beat with no action expected: action %0d token_ref %0h",
                       res.action, res.token_ref);
                failures++;
            end
            else
            begin
                want = pending_actions.pop_front();
                check_field("action", 16'(want.action), 16'(res.action));
                check_field("name_id", want.name_id, res.name_id);
                check_field("token_ref", want.token_ref, res.token_ref);
                check_field("arg_count", 16'(want.arg_count), 16'(res.arg_count));
                check_field("has_body", 16'(want.has_body), 16'(res.has_body));
                check_field("error_code", 16'(want.error_code), 16'(res.error_code));
                check_field("nesting", 16'(want.nesting), 16'(res.nesting));
                check_field("last", 16'(want.last), 16'(res.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        int gap;
        @(negedge clk);
        forever
        begin
            if (hold_len != 0)
            begin
                gap = hold_len;
                hold_len = 0;
            end
            else
                gap = rx_idle ? $urandom_range(0, 13) : 0;
            if (gap != 0)
            begin
                res_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            res_stall = 1'b0;
            do @(posedge clk); while (res_valid !== 1'b1);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------
    // Token side
    // ---------------------------------------------------------------
    function automatic logic [15:0] rand_id();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [7:0] rand_char();
        return 8'($urandom_range(0, 255));
    endfunction

    // One token beat; valid stays up until the beat is taken
    task automatic send_token(input logic [2:0] kind, input logic [7:0] ch,
                              input logic [15:0] id);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            tok_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tok.kind     = kind;
        tok.lit_char = ch;
        tok.token_id = id;
        tok_valid    = 1'b1;
        do @(posedge clk); while (tok_stall !== 1'b0);
        if (ps_state != ST_HALT || kind == K_RESTART)
            tokens_live++;
        else
            tokens_ignored++;
        parse_token(kind, ch, id);
    endtask

    task automatic send_lit(input logic [7:0] ch);
        send_token(K_LIT, ch, rand_id());
    endtask

    task automatic send_arg();
        send_token($urandom_range(0, 1) ? K_BARE : K_QUOTED, rand_char(), rand_id());
    endtask

    task automatic send_restart();
        send_token(K_RESTART, rand_char(), rand_id());
    endtask

    // name ( args ) with optional trailing comma; body brace left to the caller
    task automatic send_header(input int n_args, input bit trailing);
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_LPAREN);
        for (int i = 0; i < n_args; i++)
        begin
            send_arg();
            if (i < n_args - 1 || trailing)
                send_lit(CH_COMMA);
        end
        send_lit(CH_RPAREN);
    endtask

    // Any kind but restart, with literal characters biased toward the grammar's own
    task automatic send_noise();
        logic [7:0] ch;
        case ($urandom_range(0, 7))
            0: ch = CH_LBRACE;
            1: ch = CH_RBRACE;
            2: ch = CH_LPAREN;
            3: ch = CH_RPAREN;
            4: ch = CH_COMMA;
            default: ch = rand_char();
        endcase
        send_token(3'($urandom_range(0, 6)), ch, rand_id());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        tok_valid = 1'b0;
        while (pending_actions.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_pass_through();
        send_token(K_COMMENT, 8'h00, 16'h0000);
        send_token(K_CODE, 8'hFF, 16'hFFFF);
        send_token(K_BARE, 8'hFF, 16'hFFFF);
        send_token(K_BARE, 8'h00, 16'h0000);
        send_token(K_BARE, 8'h55, 16'hA5A5);
        send_token(K_QUOTED, 8'hAA, 16'h5A5A);
        send_token(K_EOI, 8'h00, 16'h1234);
    endtask

    task automatic test_blocks();
        // header with body, then a comment inside
        send_header(2, 1'b0);
        send_lit(CH_LBRACE);
        send_token(K_COMMENT, rand_char(), rand_id());
        // bodiless header resolved by a closing brace: two beats
        send_header(0, 1'b0);
        send_lit(CH_RBRACE);
        // bodiless header resolved by code, by end of input, by a new name
        send_header(1, 1'b0);
        send_token(K_CODE, rand_char(), rand_id());
        send_header(0, 1'b0);
        send_token(K_EOI, rand_char(), rand_id());
        send_header(0, 1'b0);
        send_token(K_BARE, rand_char(), rand_id());
        send_token(K_QUOTED, rand_char(), rand_id());
        // trailing comma is allowed
        send_header(1, 1'b1);
        send_lit(CH_LBRACE);
        send_lit(CH_RBRACE);
    endtask

    task automatic test_errors();
        // end of input with a block still open
        send_header(0, 1'b0);
        send_lit(CH_LBRACE);
        send_token(K_EOI, rand_char(), rand_id());
        send_restart();
        // close without open, then wrong literal and other kind at top
        send_lit(CH_RBRACE);
        send_restart();
        send_lit(CH_LPAREN);
        send_restart();
        send_token(K_OTHER, rand_char(), rand_id());
        send_token(K_COMMENT, rand_char(), rand_id());
        send_restart();
        // errors after a name
        send_token(K_BARE, rand_char(), rand_id());
        send_token(K_EOI, rand_char(), rand_id());
        send_restart();
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_COMMA);
        send_restart();
        // errors in the argument list
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_LPAREN);
        send_token(K_COMMENT, rand_char(), rand_id());
        send_restart();
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_LPAREN);
        send_lit(8'h3B);
        send_restart();
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_LPAREN);
        send_arg();
        send_token(K_BARE, rand_char(), rand_id());
        send_restart();
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_LPAREN);
        send_arg();
        send_lit(CH_LBRACE);
        send_restart();
        // restart in the middle of a header
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_LPAREN);
        send_arg();
        send_restart();
        send_token(K_COMMENT, rand_char(), rand_id());
        // bodiless header followed by a bad kind: block then error
        send_header(0, 1'b0);
        send_token(K_OTHER, rand_char(), rand_id());
        send_restart();
    endtask

    task automatic test_arg_limit();
        send_header(MAX_ARGS, 1'b0);
        send_lit(CH_LBRACE);
        send_lit(CH_RBRACE);
        send_token(K_BARE, rand_char(), rand_id());
        send_lit(CH_LPAREN);
        for (int i = 0; i < MAX_ARGS; i++)
        begin
            send_arg();
            send_lit(CH_COMMA);
        end
        send_arg();
        send_restart();
    endtask

    task automatic test_depth_limit();
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            send_header(0, 1'b0);
            send_lit(CH_LBRACE);
        end
        send_lit(CH_RBRACE);
        send_header(1, 1'b0);
        send_lit(CH_LBRACE);
        // one level too many
        send_header(0, 1'b0);
        send_lit(CH_LBRACE);
        send_restart();
    endtask

    task automatic random_construct();
        int pick;
        int r;
        if (ps_state == ST_HALT)
        begin
            repeat ($urandom_range(0, 2)) send_noise();
            send_restart();
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            send_token($urandom_range(0, 1) ? K_COMMENT : K_CODE, rand_char(), rand_id());
        else if (pick < 35)
        begin
            send_token(K_BARE, rand_char(), rand_id());
            send_arg();
        end
        else if (pick < 65)
        begin
            r = $urandom_range(0, 19);
            send_header(r == 0 ? MAX_ARGS + 1 : r == 1 ? MAX_ARGS : $urandom_range(0, 4),
                        $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1))
                send_lit(CH_LBRACE);
        end
        else if (pick < 82)
        begin
            if (ps_depth != 0)
                send_lit(CH_RBRACE);
            else
                send_token(K_COMMENT, rand_char(), rand_id());
        end
        else if (pick < 87)
            send_token(K_EOI, rand_char(), rand_id());
        else if (pick < 97)
            send_noise();
        else
            send_restart();
    endtask

    // Receiver holds off while the sender keeps offering tokens back to back
    task automatic test_backpressure();
        wait_drained();
        hold_len = HOLD_CYCLES;
        tx_idle  = 1'b0;
        repeat (30) random_construct();
        tx_idle  = 1'b1;
    endtask

    task automatic test_random_stream();
        int goal;
        goal = tokens_live + RANDOM_ITEMS;
        while (tokens_live < goal)
        begin
            // stretches with and without idling on either side
            if ($urandom_range(0, 39) == 0)
            begin
                tx_idle = $urandom_range(0, 2) != 0;
                rx_idle = $urandom_range(0, 2) != 0;
            end
            random_construct();
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_pass_through();
        test_blocks();
        test_errors();
        test_arg_limit();
        test_depth_limit();
        test_backpressure();
        test_random_stream();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d tokens parsed, %0d ignored while halted, %0d result beats checked",
                 tokens_live, tokens_ignored, beats_checked);
        $display("Scope: commands, blocks to depth %0d, %0d-argument limit, all error codes",
                 MAX_DEPTH, MAX_ARGS);
        if (failures == 0)
            $display("nested_block_token_parser verification clean");
        else
            $display("nested_block_token_parser verification failed");
        $finish;
    end

endmodule
